// ===== rtl/sm2_prime_field_alu_assert.svh =====
// Assertion macros for the SM2 prime field unit
`ifndef SM2_PRIME_FIELD_ALU_ASSERT_SVH
`define SM2_PRIME_FIELD_ALU_ASSERT_SVH
// same-cycle implication, held off during reset
`define SM2_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sm2 field unit: same-cycle check failed");
// next-cycle implication, held off during reset
`define SM2_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sm2 field unit: next-cycle check failed");
`endif

// ===== rtl/sm2f_pkg.sv =====
// Types and constants for the SM2 prime field unit
package sm2f_pkg;

  localparam int unsigned TW = 258;

  localparam logic [255:0] P =
    256'hFFFFFFFEFFFFFFFF_FFFFFFFFFFFFFFFF_FFFFFFFF00000000_FFFFFFFFFFFFFFFF;
  localparam logic [255:0] RR =
    256'h0000000400000002_0000000100000001_00000002FFFFFFFF_0000000200000003;
  localparam logic [255:0] ONE = 256'd1;

  typedef enum logic [3:0] {
    ACT_ADD       = 4'd0,
    ACT_SUB       = 4'd1,
    ACT_DOUBLE    = 4'd2,
    ACT_NEGATE    = 4'd3,
    ACT_HALVE     = 4'd4,
    ACT_MONT_MUL  = 4'd5,
    ACT_MONT_SQR  = 4'd6,
    ACT_TO_MONT   = 4'd7,
    ACT_FROM_MONT = 4'd8
  } act_e;

  typedef struct packed {
    logic [3:0]  action;
    logic [63:0] a_limb0;
    logic [63:0] a_limb1;
    logic [63:0] a_limb2;
    logic [63:0] a_limb3;
    logic [63:0] b_limb0;
    logic [63:0] b_limb1;
    logic [63:0] b_limb2;
    logic [63:0] b_limb3;
  } in_t;

  typedef struct packed {
    logic [63:0] r_limb0;
    logic [63:0] r_limb1;
    logic [63:0] r_limb2;
    logic [63:0] r_limb3;
  } out_t;

  // carry-save partial result travelling along the cell row
  typedef struct packed {
    logic          mul;
    logic [255:0]  x;
    logic [255:0]  y;
    logic [TW-1:0] s;
    logic [TW-1:0] c;
  } cell_t;

endpackage

// ===== rtl/sm2f_cell.sv =====
// One bit step of carry-save Montgomery reduction
module sm2f_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_vld,
  input  sm2f_pkg::cell_t in_d,
  output logic           out_vld,
  output sm2f_pkg::cell_t out_d
);
  import sm2f_pkg::*;

  logic [TW:0] xy, qp, s1, c1, s2, c2;
  cell_t d_next;

  always_comb begin
    xy = in_d.x[0] ? {3'b000, in_d.y} : '0;
    s1 = {1'b0, in_d.s} ^ {1'b0, in_d.c} ^ xy;
    c1 = (({1'b0, in_d.s} & {1'b0, in_d.c}) | ({1'b0, in_d.s} & xy) |
          ({1'b0, in_d.c} & xy)) << 1;
    // quotient bit makes the sum even; p is odd
    qp = s1[0] ? {3'b000, P} : '0;
    s2 = s1 ^ c1 ^ qp;
    c2 = ((s1 & c1) | (s1 & qp) | (c1 & qp)) << 1;
    d_next = in_d;
    d_next.x = in_d.x >> 1;
    if (in_d.mul) begin
      d_next.s = s2[TW:1];
      d_next.c = c2[TW:1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_d <= d_next;
    end
  end
endmodule

// ===== rtl/sm2f_prep.sv =====
// Operand reduction, the add, subtract, double, negate and halve actions, and Montgomery operand setup
module sm2f_prep (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_vld,
  input  sm2f_pkg::in_t   in_d,
  output logic            out_vld,
  output sm2f_pkg::cell_t out_d
);
  import sm2f_pkg::*;

  logic         v1, v2;
  act_e         act1, act2;
  logic [255:0] a1, b1, a_in, b_in, a_red, b_red;
  logic [256:0] t2, t_next;
  logic [255:0] x2, y2, y_next, r3;
  logic         mul_next;
  cell_t        d_next;

  always_comb begin
    a_in  = {in_d.a_limb3, in_d.a_limb2, in_d.a_limb1, in_d.a_limb0};
    b_in  = {in_d.b_limb3, in_d.b_limb2, in_d.b_limb1, in_d.b_limb0};
    a_red = (a_in >= P) ? a_in - P : a_in;
    b_red = (b_in >= P) ? b_in - P : b_in;
  end

  always_comb begin
    t_next = '0;
    y_next = '0;
    case (act1)
      ACT_ADD:       t_next = {1'b0, a1} + {1'b0, b1};
      ACT_SUB:       t_next = {1'b0, a1} - {1'b0, b1};
      ACT_DOUBLE:    t_next = {1'b0, a1} + {1'b0, a1};
      ACT_NEGATE:    t_next = 257'd0 - {1'b0, a1};
      ACT_HALVE:     t_next = a1[0] ? {1'b0, a1} + {1'b0, P} : {1'b0, a1};
      ACT_MONT_MUL:  y_next = b1;
      ACT_MONT_SQR:  y_next = a1;
      ACT_TO_MONT:   y_next = RR;
      ACT_FROM_MONT: y_next = ONE;
      default:       t_next = '0;
    endcase
  end

  always_comb begin
    r3 = '0;
    mul_next = 1'b0;
    case (act2)
      ACT_ADD, ACT_DOUBLE: r3 = (t2 >= {1'b0, P}) ? 256'(t2 - {1'b0, P}) : t2[255:0];
      ACT_SUB, ACT_NEGATE: r3 = t2[256] ? t2[255:0] + P : t2[255:0];
      ACT_HALVE:           r3 = t2[256:1];
      ACT_MONT_MUL, ACT_MONT_SQR, ACT_TO_MONT, ACT_FROM_MONT: mul_next = 1'b1;
      default:             r3 = '0;
    endcase
    d_next.mul = mul_next;
    d_next.x   = x2;
    d_next.y   = y2;
    d_next.s   = {2'b00, r3};
    d_next.c   = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      v1 <= in_vld;
      v2 <= v1;
      out_vld <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      act1  <= act_e'(in_d.action);
      a1    <= a_red;
      b1    <= b_red;
      act2  <= act1;
      t2    <= t_next;
      x2    <= a1;
      y2    <= y_next;
      out_d <= d_next;
    end
  end
endmodule

// ===== rtl/sm2_prime_field_alu.sv =====
// Top level of the SM2 prime field arithmetic unit
// Usage:
//   Input channel in_valid/in_ready carries one action and operands a, b as
//   four 64-bit limbs each; output channel out_valid/out_ready returns the
//   result below p as four limbs. Operands at or above p are reduced first.
//   Actions: add, sub, double, negate, halve, Montgomery multiply and square,
//   to and from Montgomery form; unused codes give zero.
// Pipeline: 3 prep stages, a row of 256 bit cells doing carry-save
//   Montgomery steps, one carry-resolve stage and the output register,
//   from acceptance to out_valid. Every action takes the same path.
// Throughput: one item per cycle unless stalled; up to 261 items in flight.
// Stall: the whole pipeline advances together; while out_valid is high and
//   out_ready low, nothing moves and in_ready is low. A bubble at the output
//   lets the row advance.
// Reset: rst clears all valid flags; nothing else needs clearing.
module sm2_prime_field_alu (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  sm2f_pkg::in_t   in_item,
  output logic            out_valid,
  input  logic            out_ready,
  output sm2f_pkg::out_t  out_item
);
  import sm2f_pkg::*;

  localparam int unsigned NCELL = 256;

  logic          adv;
  logic          vld [0:NCELL];
  cell_t         stg [0:NCELL];
  logic          fv, fmul;
  logic [TW-1:0] ft;
  logic [255:0]  r_next;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  sm2f_prep u_prep (
    .clk(clk), .rst(rst), .en(adv), .in_vld(in_valid && adv), .in_d(in_item),
    .out_vld(vld[0]), .out_d(stg[0])
  );

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    sm2f_cell u_cell (
      .clk(clk), .rst(rst), .en(adv), .in_vld(vld[i]), .in_d(stg[i]),
      .out_vld(vld[i+1]), .out_d(stg[i+1])
    );
  end

  // final sum is below 2p after the Montgomery steps
  always_comb begin
    r_next = (fmul && ft >= {2'b00, P}) ? 256'(ft - {2'b00, P}) : ft[255:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fv        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      fv        <= vld[NCELL];
      out_valid <= fv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ft       <= stg[NCELL].s + stg[NCELL].c;
      fmul     <= stg[NCELL].mul;
      out_item <= {r_next[63:0], r_next[127:64], r_next[191:128], r_next[255:192]};
    end
  end
endmodule

// ===== rtl/sm2f_checker.sv =====
// Port-level checks for the SM2 prime field unit, bound to the top level
`include "sm2_prime_field_alu_assert.svh"
module sm2f_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_ready,
  input sm2f_pkg::in_t  in_item,
  input logic           out_valid,
  input logic           out_ready,
  input sm2f_pkg::out_t out_item
);
  import sm2f_pkg::*;

  logic [255:0] r_full;

  assign r_full = {out_item.r_limb3, out_item.r_limb2, out_item.r_limb1, out_item.r_limb0};

  `SM2_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `SM2_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_item))
  `SM2_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(in_item))
  `SM2_ASSERT_NOW(a_ready_tracks_out, 1'b1, in_ready == (!out_valid || out_ready))
  `SM2_ASSERT_NOW(a_result_reduced, out_valid, r_full < P)
endmodule

bind sm2_prime_field_alu sm2f_checker u_sm2f_checker (.*);

// ===== dv/sm2_prime_field_alu_checker.sv =====
// Checker for the SM2 prime field unit: predicts each result and compares it
module sm2_prime_field_alu_checker
  import sm2f_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  logic  in_ready,
  input  in_t   in_item,
  input  logic  out_valid,
  input  logic  out_ready,
  input  out_t  out_item,
  output int    fail_count,
  output int    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [255:0] field_results[$];

  function automatic logic [255:0] reduce_below_p(logic [255:0] x);
    return (x >= P) ? x - P : x;
  endfunction

  // x*y/2^256 mod p, both inputs below p
  function automatic logic [255:0] mont_product(logic [255:0] x, logic [255:0] y);
    logic [511:0] t;
    logic [512:0] q;
    logic [63:0]  m;
    t = 512'(x) * 512'(y);
    q = 513'(t);
    for (int i = 0; i < 4; i++) begin
      m = q[64*i +: 64];
      q = q + ((513'(m) * 513'(P)) << (64 * i));
    end
    q = q >> 256;
    if (q >= 513'(P)) q = q - 513'(P);
    return q[255:0];
  endfunction

  function automatic logic [255:0] field_op(in_t it);
    logic [255:0] a, b;
    logic [256:0] s;
    a = reduce_below_p({it.a_limb3, it.a_limb2, it.a_limb1, it.a_limb0});
    b = reduce_below_p({it.b_limb3, it.b_limb2, it.b_limb1, it.b_limb0});
    case (it.action)
      ACT_ADD: begin
        s = a + b;
        return (s >= P) ? 256'(s - P) : s[255:0];
      end
      ACT_SUB:    return (a >= b) ? a - b : a - b + P;
      ACT_DOUBLE: begin
        s = {a, 1'b0};
        return (s >= P) ? 256'(s - P) : s[255:0];
      end
      ACT_NEGATE: return (a == 0) ? 256'd0 : P - a;
      ACT_HALVE: begin
        s = a[0] ? 257'(a) + 257'(P) : 257'(a);
        return s[256:1];
      end
      ACT_MONT_MUL:  return mont_product(a, b);
      ACT_MONT_SQR:  return mont_product(a, a);
      ACT_TO_MONT:   return mont_product(a, RR);
      ACT_FROM_MONT: return mont_product(a, ONE);
      default:       return 256'd0;
    endcase
  endfunction

  assign pending = field_results.size();

  always @(posedge clk) begin
    logic [255:0] want, got;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (in_valid && in_ready) field_results.push_back(field_op(in_item));
      if (out_valid && out_ready) begin
        got = {out_item.r_limb3, out_item.r_limb2, out_item.r_limb1, out_item.r_limb0};
        if (field_results.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected result item %h", got);
        end else begin
          want = field_results.pop_front();
          if (want != got) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10) begin
              for (int i = 0; i < 4; i++)
                if (want[64*i +: 64] != got[64*i +: 64])
                  $display("r_limb%0d: expected %h got %h", i, want[64*i +: 64],
                           got[64*i +: 64]);
            end
          end
        end
      end
    end
  end
endmodule

// ===== dv/sm2_prime_field_alu_tb.sv =====
// Testbench top for the SM2 prime field unit: stimulus, stalls and verdict
module sm2_prime_field_alu_tb;
  import sm2f_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 261;
  localparam int N_RANDOM = 1230;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_item;
  int   fail_count, pending;
  bit   quiet = 1'b0;
  bit   long_stall = 1'b0;
  int   n_sent = 0;
  int   rx_idle = 0;

  always #5 clk = ~clk;

  sm2_prime_field_alu DUT (.*);
  sm2_prime_field_alu_checker u_checker (.*);

  function automatic logic [255:0] rand_word();
    logic [255:0] v;
    for (int i = 0; i < 8; i++) v[32*i +: 32] = $urandom;
    return v;
  endfunction

  // operand biased towards the interesting corners of the field
  function automatic logic [255:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 256'd0;
      1: return P - 256'($urandom_range(0, 3));
      2: return P + 256'($urandom_range(0, 5));
      3: return '1;
      4: return 256'($urandom_range(0, 7));
      default: return rand_word();
    endcase
  endfunction

  task automatic send_item(logic [3:0] act, logic [255:0] a, logic [255:0] b);
    in_t it;
    it.action = act;
    {it.a_limb3, it.a_limb2, it.a_limb1, it.a_limb0} = a;
    {it.b_limb3, it.b_limb2, it.b_limb1, it.b_limb0} = b;
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_sent++;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // receiver: back-pressure in random bursts, one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rx_idle   <= 0;
    end else if (long_stall) begin
      out_ready <= 1'b0;
    end else if (quiet) begin
      out_ready <= 1'b1;
    end else if (rx_idle > 0) begin
      out_ready <= 1'b0;
      rx_idle   <= rx_idle - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_ready <= 1'b0;
      rx_idle   <= $urandom_range(0, 5);
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin
    logic [3:0] act;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed corners
    for (int k = 0; k <= 8; k++) send_item(4'(k), 256'd0, 256'd0);
    for (int k = 0; k <= 8; k++) send_item(4'(k), P - 1, '1);
    send_item(ACT_NEGATE, P, 256'd5);
    send_item(ACT_HALVE, 256'd1, 256'd0);
    send_item(ACT_SUB, 256'd1, P - 1);
    send_item(4'd9, P - 1, P - 1);
    send_item(4'd15, '1, '1);
    send_item(ACT_MONT_MUL, P, P + 1);

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 300) begin
        long_stall <= 1'b1;
        fork
          begin repeat (600) @(posedge clk); long_stall <= 1'b0; end
        join_none
      end
      if (n == 700) begin
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
      end
      if (n == N_RANDOM - 200) quiet = 1'b1;
      act = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15))
                                         : 4'($urandom_range(0, 8));
      send_item(act, pick_operand(), pick_operand());
    end
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    $display("sent %0d items over all nine actions, unused codes and operands at or above p,",
             n_sent);
    $display("with random stalls on both sides, a long output hold-off and a drain pause");
    if (fail_count == 0 && pending == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/sm2f_pkg.sv
rtl/sm2f_cell.sv
rtl/sm2f_prep.sv
rtl/sm2_prime_field_alu.sv
rtl/sm2f_checker.sv
dv/sm2_prime_field_alu_checker.sv
dv/sm2_prime_field_alu_tb.sv
